// ----- hdl/sps_pkg.sv -----
// Shared types and constants for the SYN port scan detector.
package sps_pkg;

  // Configuration register indexes
  localparam logic REG_LOCAL_ADDRESS  = 1'b0;
  localparam logic REG_SCAN_THRESHOLD = 1'b1;

  localparam int CFG_W    = 32;
  localparam int THRESH_W = 5;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 5'd5;
  localparam logic [THRESH_W-1:0] THRESH_MIN   = 5'd2;
  localparam logic [THRESH_W-1:0] THRESH_MAX   = 5'd16;

  // One alert result as it leaves the block
  typedef struct packed {
    logic [31:0] attacker_ip;
    logic        continuing;
    logic [15:0] port;
    logic        last;
  } sps_result_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRC_SCAN,
    ST_INSERT,
    ST_CNT_RD,
    ST_PORT_SCAN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } sps_state_t;

  // Clamp the programmed threshold into its legal range.
  function automatic logic [THRESH_W-1:0] eff_threshold(input logic [THRESH_W-1:0] t);
    logic [THRESH_W-1:0] r;
    r = t;
    if (t < THRESH_MIN) r = THRESH_MIN;
    if (t > THRESH_MAX) r = THRESH_MAX;
    return r;
  endfunction

endpackage

// ----- hdl/syn_port_scan_detector.sv -----
// Top level of the SYN port scan detector: sequencer, tables and config.
//
// Input requests arrive on s_tvalid/s_tready with src_ip and dst_port in
// s_tdata and the tcp_over_ipv4 and syn_flag bits in s_tuser. Alerts leave
// on m_tvalid/m_tready, one request per reported port, oldest first, with
// m_tlast on the final port of a run and m_tuser set on repeated alerts.
// Registers must be written through cfg_we/cfg_index/cfg_wdata while idle;
// the block itself does not enforce this.
// One request is handled at a time; s_tready is high only while idle.
// A request that is not a SYN of interest is dropped as it is accepted.
// Otherwise the source table is scanned one entry per cycle, then the port
// list of a matching source one entry per cycle, as each table memory has
// a single read port. An alert then reads and loads each reported port in
// turn, waiting before each read until the output register can take it.
// The last result waits in an output register, so the next request is
// taken while it is held; a stalled receiver only stops a later alert.
// Reset clears the source count and the configuration; the table memories
// need no clearing since only entries below the stored counts are read.
module syn_port_scan_detector
  import sps_pkg::*;
#(
  parameter int MAX_SOURCES      = 64,
  parameter int PORTS_PER_SOURCE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // src_ip [31:0], dst_port [47:32]
  input  logic [1:0]  s_tuser,   // tcp_over_ipv4 [0], syn_flag [1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // attacker_ip [31:0], port [47:32]
  output logic        m_tuser,   // continuing
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int SW  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int SCW = $clog2(MAX_SOURCES + 1);
  localparam int PCW = $clog2(PORTS_PER_SOURCE + 1);
  localparam int AW  = $clog2(MAX_SOURCES * PORTS_PER_SOURCE);
  localparam int PSD = MAX_SOURCES * PORTS_PER_SOURCE;

  // Configuration
  logic [31:0]         local_address;
  logic [THRESH_W-1:0] scan_threshold;
  logic [THRESH_W-1:0] thr;

  // Control state
  sps_state_t state, state_next;
  logic [SCW-1:0] source_count, source_count_next;

  // Working registers of the current item
  logic [31:0]    src, src_next;
  logic [15:0]    dport, dport_next;
  logic [SCW-1:0] s_idx, s_idx_next;
  logic           pend, pend_next;
  logic [SW-1:0]  pend_idx, pend_idx_next;
  logic [SW-1:0]  src_idx, src_idx_next;
  logic [AW-1:0]  base, base_next;
  logic [PCW-1:0] cnt, cnt_next;
  logic [PCW-1:0] p, p_next;
  logic [3:0]     r, r_next;
  logic [3:0]     k, k_next;
  logic           cont, cont_next;

  // Table memories
  logic [31:0]    source_addr [MAX_SOURCES];
  logic [PCW-1:0] port_count [MAX_SOURCES];
  logic [15:0]    port_store [PSD];

  logic [31:0]    sa_rdata;
  logic [PCW-1:0] pc_rdata;
  logic [15:0]    ps_rdata;
  logic           sa_we, pc_we, ps_we;
  logic [SW-1:0]  pc_waddr;
  logic [PCW-1:0] pc_wdata;
  logic [AW-1:0]  ps_waddr, ps_raddr;

  // Output side
  logic        out_load, out_free;
  sps_result_t out_data;

  logic in_accept, hit;

  assign thr       = eff_threshold(scan_threshold);
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign ps_raddr  = base + AW'(p);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      local_address  <= '0;
      scan_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCAL_ADDRESS:  local_address  <= cfg_wdata[31:0];
        REG_SCAN_THRESHOLD: scan_threshold <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      source_count <= '0;
    end else begin
      state        <= state_next;
      source_count <= source_count_next;
    end
  end

  // Working registers, set on entry to each phase
  always_ff @(posedge clk) begin
    src      <= src_next;
    dport    <= dport_next;
    s_idx    <= s_idx_next;
    pend     <= pend_next;
    pend_idx <= pend_idx_next;
    src_idx  <= src_idx_next;
    base     <= base_next;
    cnt      <= cnt_next;
    p        <= p_next;
    r        <= r_next;
    k        <= k_next;
    cont     <= cont_next;
  end

  // Source address table
  always_ff @(posedge clk) begin
    if (sa_we) begin
      source_addr[source_count[SW-1:0]] <= src;
    end
    sa_rdata <= source_addr[s_idx[SW-1:0]];
  end

  // Port count table
  always_ff @(posedge clk) begin
    if (pc_we) begin
      port_count[pc_waddr] <= pc_wdata;
    end
    pc_rdata <= port_count[pend_idx];
  end

  // Port store, one row of ports per source
  always_ff @(posedge clk) begin
    if (ps_we) begin
      port_store[ps_waddr] <= dport;
    end
    ps_rdata <= port_store[ps_raddr];
  end

  // Sequencer: next state, register updates and table writes
  always_comb begin
    state_next        = state;
    source_count_next = source_count;
    src_next          = src;
    dport_next        = dport;
    s_idx_next        = s_idx;
    pend_next         = pend;
    pend_idx_next     = pend_idx;
    src_idx_next      = src_idx;
    base_next         = base;
    cnt_next          = cnt;
    p_next            = p;
    r_next            = r;
    k_next            = k;
    cont_next         = cont;
    sa_we             = 1'b0;
    pc_we             = 1'b0;
    ps_we             = 1'b0;
    pc_waddr          = src_idx;
    pc_wdata          = cnt + PCW'(1);
    ps_waddr          = base + AW'(cnt);
    out_load          = 1'b0;
    hit               = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          src_next   = s_tdata[31:0];
          dport_next = s_tdata[47:32];
          s_idx_next = '0;
          pend_next  = 1'b0;
          if (s_tuser[0] && s_tuser[1] && s_tdata[31:0] != local_address) begin
            state_next = ST_SRC_SCAN;
          end
        end
      end

      // Read one source entry per cycle and compare the previous read.
      ST_SRC_SCAN: begin
        hit = pend && (sa_rdata == src);
        if (hit) begin
          src_idx_next = pend_idx;
          base_next    = AW'(pend_idx) * AW'(PORTS_PER_SOURCE);
          state_next   = ST_CNT_RD;
        end else if (s_idx == source_count) begin
          if (source_count < SCW'(MAX_SOURCES)) begin
            base_next  = AW'(source_count) * AW'(PORTS_PER_SOURCE);
            state_next = ST_INSERT;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          pend_next     = 1'b1;
          pend_idx_next = s_idx[SW-1:0];
          s_idx_next    = s_idx + SCW'(1);
        end
      end

      // New source: store address, first port and a count of one.
      ST_INSERT: begin
        sa_we             = 1'b1;
        pc_we             = 1'b1;
        pc_waddr          = source_count[SW-1:0];
        pc_wdata          = PCW'(1);
        ps_we             = 1'b1;
        ps_waddr          = base;
        source_count_next = source_count + SCW'(1);
        state_next        = ST_IDLE;
      end

      // Port count of the matching source is now available.
      ST_CNT_RD: begin
        cnt_next   = (pc_rdata > PCW'(PORTS_PER_SOURCE)) ? PCW'(PORTS_PER_SOURCE)
                                                           : pc_rdata;
        p_next     = '0;
        r_next     = '0;
        pend_next  = 1'b0;
        state_next = ST_PORT_SCAN;
      end

      // Read one stored port per cycle; r tracks the count modulo threshold.
      ST_PORT_SCAN: begin
        hit = pend && (ps_rdata == dport);
        if (hit) begin
          state_next = ST_IDLE;
        end else if (p == cnt) begin
          if (cnt >= PCW'(PORTS_PER_SOURCE)) begin
            state_next = ST_IDLE;
          end else begin
            ps_we = 1'b1;
            pc_we = 1'b1;
            if (({1'b0, r} + 5'd1) == thr) begin
              p_next     = cnt + PCW'(1) - PCW'(thr);
              k_next     = '0;
              cont_next  = (cnt >= PCW'(thr));
              state_next = ST_EMIT_RD;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          pend_next = 1'b1;
          p_next    = p + PCW'(1);
          r_next    = (({1'b0, r} + 5'd1) == thr) ? 4'd0 : r + 4'd1;
        end
      end

      // Issue the read of the next reported port once the output is free.
      ST_EMIT_RD: begin
        if (out_free) begin
          state_next = ST_EMIT_LD;
        end
      end

      ST_EMIT_LD: begin
        out_load = 1'b1;
        p_next   = p + PCW'(1);
        k_next   = k + 4'd1;
        if (({1'b0, k} + 5'd1) == thr) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EMIT_RD;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Result assembled from the port read and the item registers
  always_comb begin
    out_data.attacker_ip = src;
    out_data.continuing  = cont;
    out_data.port        = ps_rdata;
    out_data.last        = (({1'b0, k} + 5'd1) == thr);
  end

  sps_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .load_data (out_data),
    .free      (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // The source table never claims more entries than it has.
  assert property (@(posedge clk) disable iff (rst)
    source_count <= SCW'(MAX_SOURCES))
    else $error("source count beyond table size");

  // A result is loaded only when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> $past(out_free))
    else $error("result loaded over a held result");

  // A run never reports more ports than the threshold.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_LD) |-> ({1'b0, k} < thr))
    else $error("alert run longer than threshold");

  // Reset empties the output register.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

// ----- hdl/sps_out_stage.sv -----
// Output register that holds one alert result until the receiver takes it.
module sps_out_stage
  import sps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  sps_result_t load_data,
  output logic        free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // attacker_ip [31:0], port [47:32]
  output logic        m_tuser,   // continuing
  output logic        m_tlast
);

  sps_result_t held;

  // The register can take a new result when empty or being drained now.
  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_data;
    end
  end

  assign m_tdata = {held.port, held.attacker_ip};
  assign m_tuser = held.continuing;
  assign m_tlast = held.last;

endmodule

// ----- bench/scan_alert_checker.sv -----
// Checker for the SYN port scan detector: tracks register writes, predicts alert ports, compares.
`timescale 1ns / 100ps

module scan_alert_checker
  import sps_pkg::*;
#(
  parameter int NUM_SOURCES = 64,
  parameter int LIST_DEPTH  = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [47:0]      s_tdata,   // src_ip [31:0], dst_port [47:32]
  input  logic [1:0]       s_tuser,   // tcp_over_ipv4 [0], syn_flag [1]
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [47:0]      m_tdata,   // attacker_ip [31:0], port [47:32]
  input  logic             m_tuser,   // continuing
  input  logic             m_tlast,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               alerts_pending,
  output int               ports_checked,
  output int               alert_runs
);

  // Shadow copy of the registers and the source/port tables.
  logic [31:0]         own_addr;
  logic [THRESH_W-1:0] thresh_reg;
  int                  src_total;
  logic [31:0]         src_table [NUM_SOURCES];
  int                  list_len  [NUM_SOURCES];
  logic [15:0]         port_list [NUM_SOURCES][LIST_DEPTH];
  sps_result_t         expected_alerts [$];

  // Ports per alert: the programmed value held inside its legal range.
  function automatic int alert_size(input logic [THRESH_W-1:0] t);
    int n;
    n = t;
    if (n < THRESH_MIN) n = THRESH_MIN;
    else if (n > THRESH_MAX) n = THRESH_MAX;
    return n;
  endfunction

  // Update the tables for one request and queue the alert ports it causes.
  task automatic predict_alerts(input logic [47:0] data, input logic [1:0] flags);
    logic [31:0] src;
    logic [15:0] dport;
    int          slot;
    int          n;
    int          thr;
    bit          seen;
    sps_result_t r;
    src   = data[31:0];
    dport = data[47:32];
    if (!flags[0] || !flags[1] || src == own_addr) return;

    slot = -1;
    for (int s = 0; s < src_total; s++) begin
      if (slot < 0 && src_table[s] == src) slot = s;
    end

    // A new source is recorded with its first port; a full table drops it.
    if (slot < 0) begin
      if (src_total < NUM_SOURCES) begin
        src_table[src_total]    = src;
        list_len[src_total]     = 1;
        port_list[src_total][0] = dport;
        src_total++;
      end
      return;
    end

    // Known source: only a port it has not tried yet counts, while room is left.
    n    = list_len[slot];
    seen = 1'b0;
    for (int p = 0; p < n; p++) begin
      if (port_list[slot][p] == dport) seen = 1'b1;
    end
    if (seen || n >= LIST_DEPTH) return;
    port_list[slot][n] = dport;
    n++;
    list_len[slot] = n;

    // Every multiple of the threshold reports the newest threshold ports.
    thr = alert_size(thresh_reg);
    if (n % thr != 0) return;
    for (int k = 0; k < thr; k++) begin
      r.attacker_ip = src;
      r.continuing  = (n > thr);
      r.port        = port_list[slot][n - thr + k];
      r.last        = (k == thr - 1);
      expected_alerts.push_back(r);
    end
  endtask

  // Compare one received alert port with the oldest expected one.
  task automatic check_alert(input sps_result_t got);
    sps_result_t want;
    ports_checked++;
    if (got.last) alert_runs++;
    if (expected_alerts.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected alert port: ip %h cont %0d port %h last %0d",
                 $time, got.attacker_ip, got.continuing, got.port, got.last);
      mismatches++;
      return;
    end
    want = expected_alerts.pop_front();
    if (got.attacker_ip !== want.attacker_ip || got.continuing !== want.continuing ||
        got.port !== want.port || got.last !== want.last) begin
      if (mismatches < 10)
        $display("%0t: alert mismatch: expected ip %h cont %0d port %h last %0d, got ip %h cont %0d port %h last %0d",
                 $time, want.attacker_ip, want.continuing, want.port, want.last,
                 got.attacker_ip, got.continuing, got.port, got.last);
      mismatches++;
    end
  endtask

  // Watch all three ports; results are checked before a new request is predicted.
  always @(posedge clk) begin
    sps_result_t got;
    if (rst) begin
      own_addr      = '0;
      thresh_reg    = THRESH_RESET;
      src_total     = 0;
      mismatches    = 0;
      ports_checked = 0;
      alert_runs    = 0;
      expected_alerts.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_LOCAL_ADDRESS) own_addr = cfg_wdata[31:0];
        else if (cfg_index == REG_SCAN_THRESHOLD) thresh_reg = cfg_wdata[THRESH_W-1:0];
      end
      if (m_tvalid && m_tready) begin
        got.attacker_ip = m_tdata[31:0];
        got.continuing  = m_tuser;
        got.port        = m_tdata[47:32];
        got.last        = m_tlast;
        check_alert(got);
      end
      if (s_tvalid && s_tready) predict_alerts(s_tdata, s_tuser);
    end
    alerts_pending <= expected_alerts.size();
  end

endmodule

// ----- bench/tb_syn_port_scan_detector.sv -----
// Testbench top for the SYN port scan detector: stimulus, register setup and verdict.
`timescale 1ns / 100ps

module tb_syn_port_scan_detector;
  import sps_pkg::*;

  localparam int NUM_SOURCES   = 64;
  localparam int LIST_DEPTH    = 64;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 1500;
  localparam int CYCLE_LIMIT   = 1_000_000;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [47:0]      s_tdata   = '0;
  logic [1:0]       s_tuser   = '0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [47:0]      m_tdata;
  logic             m_tuser;
  logic             m_tlast;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = REG_LOCAL_ADDRESS;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int mismatches;
  int alerts_pending;
  int ports_checked;
  int alert_runs;
  int cycle_count   = 0;
  int requests_sent = 0;
  int phases_run    = 0;
  int hold_reqs     = 0;
  bit idle_on       = 1'b1;

  // Sources that have scanned so far, used to pick attackers and local addresses.
  logic [31:0] attackers [$];

  // Threshold values for the scan phases, including ones outside the legal range.
  logic [THRESH_W-1:0] warmup_thr [7] = '{5'd2, 5'd17, 5'd3, 5'd1, 5'd8, 5'd16, 5'd4};
  logic [THRESH_W-1:0] late_thr   [3] = '{5'd0, 5'd3, 5'd2};

  always #10 clk = ~clk;

  syn_port_scan_detector #(
    .MAX_SOURCES      (NUM_SOURCES),
    .PORTS_PER_SOURCE (LIST_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  scan_alert_checker #(
    .NUM_SOURCES (NUM_SOURCES),
    .LIST_DEPTH  (LIST_DEPTH)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .alerts_pending (alerts_pending),
    .ports_checked  (ports_checked),
    .alert_runs     (alert_runs)
  );

  // Idle stretch length: mostly none or short, now and then long.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d alert ports outstanding",
               cycle_count, alerts_pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off when one is requested.
  initial begin : result_sink
    int stall_left;
    int holds_served;
    stall_left   = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        holds_served = hold_reqs;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 99) < 30) stall_left = gap_len();
      end
    end
  end

  // Offer one request, with an optional idle gap first; returns at the accepting edge.
  task automatic send_request(input logic tcp, input logic syn, input logic [31:0] src,
                              input logic [15:0] dport);
    int g;
    g = idle_on ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {dport, src};
    s_tuser  <= {syn, tcp};
    do @(posedge clk); while (!s_tready);
    requests_sent++;
  endtask

  // Stop sending, wait for every expected alert port, then let the block settle.
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (alerts_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    phases_run++;
    idle_on = (phases_run % 3 != 2);
  endtask

  // Write both registers back to back; junk in the unused threshold bits.
  task automatic set_config(input logic [31:0] addr, input logic [THRESH_W-1:0] thr);
    logic [31:0] junk;
    junk = $urandom();
    cfg_we    <= 1'b1;
    cfg_index <= REG_LOCAL_ADDRESS;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_index <= REG_SCAN_THRESHOLD;
    cfg_wdata <= {junk[31:THRESH_W], thr};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Requests the block must ignore: not TCP, no SYN, or from the local address.
  task automatic send_noise(input logic [31:0] own);
    logic [31:0] r;
    logic [31:0] a;
    r = $urandom();
    a = $urandom();
    if (attackers.size() > 0 && r[2]) a = attackers[$urandom_range(0, attackers.size() - 1)];
    case (r[1:0])
      2'd0:    send_request(1'b0, r[3], a, r[31:16]);
      2'd1:    send_request(1'b1, 1'b0, a, r[31:16]);
      2'd2:    send_request(1'b0, 1'b0, a, r[31:16]);
      default: send_request(1'b1, 1'b1, own, r[31:16]);
    endcase
  endtask

  // A phase of scans from a few attackers with random ports, mixed with noise.
  task automatic run_scan_phase(input logic [THRESH_W-1:0] thr, input int n_items,
                                input bit focused);
    logic [31:0] own;
    logic [31:0] src;
    logic [31:0] r;
    logic [15:0] dport;
    int          pick;
    int          span;
    r    = $urandom();
    pick = $urandom_range(0, 9);
    // The local address sometimes mutes a known attacker.
    if (pick < 2 && attackers.size() > 0) own = attackers[$urandom_range(0, attackers.size() - 1)];
    else if (pick == 2) own = '0;
    else if (pick == 3) own = '1;
    else own = r;
    set_config(own, thr);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      r    = $urandom();
      if (pick < 15) begin
        send_noise(own);
      end else begin
        if (pick < 22 || attackers.size() == 0) begin
          src = r;
          attackers.push_back(src);
        end else if (focused) begin
          span = (attackers.size() < 4) ? attackers.size() : 4;
          src  = attackers[attackers.size() - 1 - $urandom_range(0, span - 1)];
        end else begin
          src = attackers[$urandom_range(0, attackers.size() - 1)];
        end
        // Half the ports come from a narrow range so that repeats are common.
        r = $urandom();
        if (r[31]) dport = r[15:0];
        else dport = 16'd20 + {11'd0, r[20:16]};
        send_request(1'b1, 1'b1, src, dport);
      end
    end
    finish_phase();
  endtask

  // Main stimulus.
  initial begin : stimulus
    logic [31:0] r;
    logic [31:0] src;
    logic [15:0] dport;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: local address zero, threshold five.
    send_request(1'b1, 1'b1, 32'h0000_0000, 16'h0001);
    send_request(1'b0, 1'b1, 32'hFFFF_FFFF, 16'h0050);
    send_request(1'b1, 1'b0, 32'hFFFF_FFFF, 16'h0050);
    send_request(1'b0, 1'b0, 32'hFFFF_FFFF, 16'h0050);
    send_request(1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(1'b1, 1'b1, 32'hFFFF_FFFF, 16'h0000);
    send_request(1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(1'b1, 1'b0, 32'hFFFF_FFFF, 16'h0016);
    send_request(1'b1, 1'b1, 32'hFFFF_FFFF, 16'h0016);
    send_request(1'b1, 1'b1, 32'hFFFF_FFFF, 16'h0017);
    send_request(1'b1, 1'b1, 32'hFFFF_FFFF, 16'h0050);
    finish_phase();

    // All-ones local address and a threshold below the minimum.
    set_config(32'hFFFF_FFFF, 5'd0);
    send_request(1'b1, 1'b1, 32'hFFFF_FFFF, 16'h0051);
    send_request(1'b1, 1'b1, 32'h0000_0000, 16'h8000);
    send_request(1'b1, 1'b1, 32'h0000_0000, 16'h7FFF);
    send_request(1'b1, 1'b1, 32'h0000_0000, 16'h5555);
    send_request(1'b1, 1'b1, 32'h0000_0000, 16'hAAAA);
    send_request(1'b1, 1'b1, 32'h0000_0000, 16'hAAAA);
    finish_phase();

    // A threshold change lands an older source on a multiple straight away.
    set_config(32'h0000_0001, 5'd1);
    send_request(1'b1, 1'b1, 32'hFFFF_FFFF, 16'h0443);
    finish_phase();

    // Warm-up scans across a spread of thresholds.
    for (int p = 0; p < 7; p++) run_scan_phase(warmup_thr[p], 20, 1'b1);

    // One source walks past its full port list at the top threshold, while the
    // result side holds off long enough for the block to back up its input.
    r   = $urandom();
    src = $urandom();
    attackers.push_back(src);
    dport = r[15:0];
    set_config(r ^ 32'h5A5A_0001, 5'd31);
    for (int i = 0; i < 70; i++) begin
      if (i == 14) hold_reqs <= hold_reqs + 1;
      send_request(1'b1, 1'b1, src, dport);
      dport = dport + 16'd1;
    end
    finish_phase();

    // Flood of new sources until the source table overflows.
    set_config($urandom(), 5'd5);
    for (int i = 0; i < 70; i++) begin
      r = $urandom();
      if (i % 17 == 16) begin
        send_request(1'b1, 1'b1, attackers[$urandom_range(0, attackers.size() - 1)], r[15:0]);
      end else begin
        src = $urandom();
        attackers.push_back(src);
        send_request(1'b1, 1'b1, src, r[31:16]);
      end
    end
    finish_phase();

    // Scans with a full source table: only known sources can still raise alerts.
    for (int p = 0; p < 3; p++) run_scan_phase(late_thr[p], 22, 1'b0);

    $display("Covered %0d requests over %0d phases: noise, repeats, clamped thresholds,",
             requests_sent, phases_run);
    $display("full port list and full source table; %0d alert ports in %0d alerts checked.",
             ports_checked, alert_runs);
    if (mismatches == 0 && alerts_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
